/* rtl/mpms_pkg.sv */
// ----------------------------------------------------------------------------
// mpms_pkg
// Shared types, constants and the sine helper stage function for the
// multitone phase-modulated sine sum.
// ----------------------------------------------------------------------------
package mpms_pkg;

  // Operation codes of an input item.
  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Sine polynomial coefficients.
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;

  // Phase split of the sine: quadrant and mirrored 17-bit offset.
  typedef struct packed {
    logic [1:0]  quad;
    logic [16:0] x;
  } sin_arg_t;

  function automatic sin_arg_t sin_prep(input logic [31:0] phase);
    sin_arg_t r;
    logic [16:0] x;
    x = {1'b0, phase[29:14]};
    r.quad = phase[31:30];
    r.x = phase[30] ? (17'd65536 - x) : x;
    return r;
  endfunction

endpackage

/* rtl/mpms_if.sv */
// ----------------------------------------------------------------------------
// mpms_in_if / mpms_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface mpms_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  tone;
  logic signed [15:0] amp_value;
  logic [15:0] carrier_value;
  logic [31:0] mod_freq_value;
  logic [31:0] mod_depth_value;
  logic [31:0] arg;
  modport source (output valid, op, tone, amp_value, carrier_value, mod_freq_value,
                  mod_depth_value, arg, input ready);
  modport sink (input valid, op, tone, amp_value, carrier_value, mod_freq_value,
                mod_depth_value, arg, output ready);
endinterface

interface mpms_out_if;
  logic        valid;
  logic        ready;
  logic signed [19:0] sum_value;
  modport source (output valid, sum_value, input ready);
  modport sink (input valid, sum_value, output ready);
endinterface

/* rtl/mpms_sine.sv */
// ----------------------------------------------------------------------------
// mpms_sine
// Pipelined fifth-order polynomial sine, Q1.15 out, with a passthrough tag.
// Five register stages; advances when en_i is high.
// ----------------------------------------------------------------------------
module mpms_sine
  import mpms_pkg::*;
#(
  parameter int TAG_W = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [31:0]              phase_i,
  input  logic [TAG_W-1:0]         tag_i,
  output logic signed [16:0]       sin_o,
  output logic [TAG_W-1:0]         tag_o
);

  sin_arg_t          a1_q, a2_q, a3_q, a4_q;
  logic [TAG_W-1:0]  t1_q, t2_q, t3_q, t4_q, t5_q;
  logic [16:0]       z2_q;
  logic [15:0]       t3_q_v;
  logic [16:0]       r_q;
  logic signed [16:0] s_q;
  logic [33:0]       sq;
  logic [29:0]       c1;
  logic [15:0]       t1v;
  logic [33:0]       t3p;
  logic [34:0]       rp;
  logic [32:0]       sp;
  logic [16:0]       sv;

  // Square of the offset, then the inner terms, then the outer product.
  assign sq  = 34'(a1_q.x) * 34'(a1_q.x);
  assign c1  = 30'(SIN_C) * 30'(z2_q);
  assign t1v = 16'(c1 >> 16);
  assign t3p = 34'(z2_q) * 34'(SIN_B - t1v);
  assign rp  = 35'(a3_q.x) * 35'(SIN_A - 17'(t3_q_v));
  assign sp  = 33'(r_q) * 33'd32767 + 33'd32768;
  assign sv  = (sp[32:16] > 17'd32767) ? 17'd32767 : sp[32:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= sin_prep(phase_i);
      z2_q   <= 17'(sq >> 16);
      a2_q   <= a1_q;
      t3_q_v <= 16'(t3p >> 16);
      a3_q   <= a2_q;
      r_q    <= 17'(rp >> 16);
      a4_q   <= a3_q;
      s_q    <= a4_q.quad[1] ? -$signed(sv) : $signed(sv);
    end
  end

  // Tags carry the valid bits, so they start cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
      t4_q <= '0;
      t5_q <= '0;
    end else if (en_i) begin
      t1_q <= tag_i;
      t2_q <= t1_q;
      t3_q <= t2_q;
      t4_q <= t3_q;
      t5_q <= t4_q;
    end
  end

  assign sin_o = s_q;
  assign tag_o = t5_q;

endmodule

/* rtl/multitone_phase_mod_sum_top.sv */
// ----------------------------------------------------------------------------
// multitone_phase_mod_sum_top
// Sum of phase-modulated sine tones over a loaded coefficient table.
// ----------------------------------------------------------------------------
// An evaluate transfer closes the input while the issue sequencer sends one
// tone a cycle, unless a waiting result stalls it, into a pipeline of sixteen
// register stages (stage A, two five-stage sines with stages B, C and D
// between them, stage E and the accumulator). A result waiting at the output
// freezes the whole pipeline. Loads are held off only while tones are being
// issued; tones already issued carry their own coefficients.
module multitone_phase_mod_sum_top
  import mpms_pkg::*;
#(
  parameter int NUM_TONES = 9
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mpms_in_if.sink  in_i,
  mpms_out_if.source out_o
);

  localparam int IW = $clog2(NUM_TONES + 1);
  localparam int TW = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;

  logic signed [15:0] amp_q   [NUM_TONES];
  logic [15:0]        car_q   [NUM_TONES];
  logic [31:0]        frq_q   [NUM_TONES];
  logic [31:0]        dep_q   [NUM_TONES];

  logic          busy_q;
  logic [IW-1:0] cnt_q;
  logic [31:0]   t_q;
  logic          run;
  logic [TW-1:0] ti;

  // Whole pipeline advances unless the output holds an untaken result.
  assign run = !(out_o.valid && !out_o.ready);
  assign in_i.ready = !busy_q;
  assign ti = cnt_q[TW-1:0];

  // Coefficient table writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        amp_q[i] <= '0; car_q[i] <= '0; frq_q[i] <= '0; dep_q[i] <= '0;
      end
    end else if (in_i.valid && in_i.ready && in_i.op == OP_LOAD &&
                 32'(in_i.tone) < 32'(NUM_TONES)) begin
      amp_q[TW'(in_i.tone)] <= in_i.amp_value;
      car_q[TW'(in_i.tone)] <= in_i.carrier_value;
      frq_q[TW'(in_i.tone)] <= in_i.mod_freq_value;
      dep_q[TW'(in_i.tone)] <= in_i.mod_depth_value;
    end
  end

  // Issue sequencer: one tone per advancing cycle.
  logic issue, last;
  assign issue = busy_q && run;
  assign last  = issue && (cnt_q == IW'(NUM_TONES - 1));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (in_i.valid && in_i.ready && in_i.op == OP_EVAL) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (issue) begin
      if (last) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) t_q <= in_i.arg;
  end

  // Tag carried with each tone: valid, last, amp, carrier, depth, t.
  typedef struct packed {
    logic        v;
    logic        l;
    logic signed [15:0] a;
    logic [15:0] c;
    logic [31:0] m;
    logic [31:0] t;
  } tag_t;
  localparam int TGW = $bits(tag_t);

  // Stage A: F*t product.
  logic [63:0] fp_q;
  tag_t        ta_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ta_q <= '0;
    end else if (run) begin
      ta_q.v <= issue;
      ta_q.l <= last;
      ta_q.a <= amp_q[ti];
      ta_q.c <= car_q[ti];
      ta_q.m <= dep_q[ti];
      ta_q.t <= t_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (run) fp_q <= 64'(frq_q[ti]) * 64'(t_q);
  end

  // First sine on the modulation phase.
  logic signed [16:0] s1;
  tag_t               tb;
  logic [TGW-1:0]     tb_raw;
  mpms_sine #(.TAG_W(TGW)) u_sin1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(run), .phase_i(fp_q[38:7]),
    .tag_i(ta_q), .sin_o(s1), .tag_o(tb_raw)
  );
  assign tb = tag_t'(tb_raw);

  // Stage B: m*s1, signed 50 bits.
  logic signed [49:0] ms_q;
  tag_t               tc_q;
  always_ff @(posedge clk_i) begin
    if (run) ms_q <= $signed({1'b0, tb.m}) * 50'(s1);
  end

  // Stage C/D: (m*s1)*t modulo 2^64 split into two partial products.
  logic [56:0]        qlo_q;
  logic signed [57:0] qhi_q;
  tag_t               td_q, te_q;
  logic [31:0]        p2;
  logic [63:0]        q;
  always_ff @(posedge clk_i) begin
    if (run) begin
      qlo_q <= ms_q[24:0] * tc_q.t;
      qhi_q <= $signed(ms_q[49:25]) * $signed({1'b0, tc_q.t});
    end
  end
  assign q  = 64'(qlo_q) + 64'({qhi_q, 25'd0});
  assign p2 = {td_q.c, 16'd0} + q[55:24];
  logic [31:0] p2_q;
  always_ff @(posedge clk_i) begin
    if (run) p2_q <= p2;
  end

  // Tags between the two sines, valid bits cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      td_q <= '0;
      te_q <= '0;
    end else if (run) begin
      tc_q <= tb;
      td_q <= tc_q;
      te_q <= td_q;
    end
  end

  // Second sine on the output phase.
  logic signed [16:0] s2;
  logic [TGW-1:0]     tf_raw;
  tag_t               tf;
  mpms_sine #(.TAG_W(TGW)) u_sin2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(run), .phase_i(p2_q),
    .tag_i(te_q), .sin_o(s2), .tag_o(tf_raw)
  );
  assign tf = tag_t'(tf_raw);

  // Stage E: amplitude product and floor shift.
  logic signed [32:0] pr_q;
  logic               gv_q, gl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gv_q <= 1'b0;
    else if (run) gv_q <= tf.v;
  end
  always_ff @(posedge clk_i) begin
    if (run) begin
      pr_q <= 33'(tf.a) * 33'(s2);
      gl_q <= tf.l;
    end
  end

  // Accumulate the terms and present the sum.
  logic signed [19:0] acc_q, term;
  logic               ov_q;
  logic signed [19:0] res_q;
  assign term = 20'(pr_q >>> 15);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready) ov_q <= 1'b0;
      if (run && gv_q) begin
        if (gl_q) begin
          acc_q <= '0;
          ov_q  <= 1'b1;
        end else begin
          acc_q <= acc_q + term;
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (run && gv_q && gl_q) res_q <= acc_q + term;
  end
  assign out_o.valid     = ov_q;
  assign out_o.sum_value = res_q;

endmodule

/* rtl/mpms_checker.sv */
// ----------------------------------------------------------------------------
// mpms_checker
// Port-level checks of the sum block, bound to the top level.
// ----------------------------------------------------------------------------
module mpms_checker
  import mpms_pkg::*;
#(
  parameter int NUM_TONES = 9
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_op_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [19:0] out_sum_i
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sum_i))
    else $error("result changed");

  // An evaluate transfer keeps the input closed while its tones are issued.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_EVAL |=> !in_ready_i [*NUM_TONES])
    else $error("eval not busy");

  // A load leaves the input open.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_LOAD |=> in_ready_i)
    else $error("load blocked");
endmodule

bind multitone_phase_mod_sum_top mpms_checker #(.NUM_TONES(NUM_TONES)) u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .in_op_i(in_i.op), .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .out_sum_i(out_o.sum_value)
);
